// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define DIU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define DIU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define DIU_ASSERT(label, clk, rst_n, prop)
`define DIU_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: src/diu_pkg.sv
// Types, constants and helpers for the dictionary index unpacker.
`default_nettype none
package diu_pkg;

  localparam int MaxSymbols = 16;
  localparam int SizeBits   = 5;
  localparam int IdxBits    = 4;
  localparam int CharBits   = 7;
  localparam int CarryBits  = 3;
  localparam int QueueBits  = CharBits + CarryBits;
  localparam int MaxGroups  = 4;
  localparam int SymBits    = 8;
  localparam int DictBits   = MaxSymbols * SymBits;

  typedef enum logic [1:0] {
    RegDictSize    = 2'd0,
    RegEntriesLow  = 2'd1,
    RegEntriesHigh = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [QueueBits-1:0] bits;
    logic [2:0]           ngroups;
    logic [2:0]           width;
  } job_t;

  typedef struct packed {
    logic [SizeBits-1:0] size;
    logic [DictBits-1:0] entries;
  } dict_cfg_t;

  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] size);
    if (size > SizeBits'(MaxSymbols)) begin
      return SizeBits'(MaxSymbols);
    end
    return size;
  endfunction

  function automatic logic [2:0] group_width(input logic [SizeBits-1:0] size);
    if (size <= SizeBits'(4)) begin
      return 3'd2;
    end
    if (size <= SizeBits'(8)) begin
      return 3'd3;
    end
    return 3'd4;
  endfunction

endpackage
`default_nettype wire

// File: src/diu_front.sv
// Front end: merges carry bits with each character and counts its groups.
`default_nettype none
module diu_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [diu_pkg::CharBits-1:0] code_char_i,
  input  wire logic                         stream_start_i,
  input  wire logic [2:0]                   width_i,
  input  wire logic                         clear_i,
  output logic                              push_o,
  output diu_pkg::job_t                     job_o,
  input  wire logic                         full_i
);
  import diu_pkg::*;

  logic [CarryBits-1:0] carry_bits_q, carry_bits_d;
  logic [1:0]           carry_count_q, carry_count_d;
  logic [1:0]           cnt;
  logic [CarryBits-1:0] cbits;
  logic [QueueBits-1:0] queue;
  logic [QueueBits-1:0] left;
  logic [3:0]           qlen;
  logic [3:0]           rem;
  logic [1:0]           rem_cap;
  logic [2:0]           ngroups;
  logic                 accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    cnt   = stream_start_i ? 2'd0 : carry_count_q;
    cbits = stream_start_i ? '0 : carry_bits_q;
    queue = ({{CarryBits{1'b0}}, code_char_i} << cnt) | {{CharBits{1'b0}}, cbits};
    qlen  = 4'(cnt) + 4'(CharBits);
    rem     = qlen;
    ngroups = '0;
    for (int i = 0; i < MaxGroups; i++) begin
      if (rem >= {1'b0, width_i}) begin
        rem     = rem - {1'b0, width_i};
        ngroups = ngroups + 3'd1;
      end
    end
    rem_cap = (rem > 4'd3) ? 2'd3 : rem[1:0];
    left    = queue >> (qlen - rem);
    job_o.bits    = queue;
    job_o.ngroups = ngroups;
    job_o.width   = width_i;
    carry_count_d = carry_count_q;
    carry_bits_d  = carry_bits_q;
    if (clear_i) begin
      carry_count_d = '0;
      carry_bits_d  = '0;
    end else if (accept) begin
      carry_count_d = rem_cap;
      carry_bits_d  = left[CarryBits-1:0] & ((CarryBits'(1) << rem_cap) - CarryBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_bits_q  <= '0;
      carry_count_q <= '0;
    end else begin
      carry_bits_q  <= carry_bits_d;
      carry_count_q <= carry_count_d;
    end
  end

endmodule
`default_nettype wire

// File: src/diu_queue.sv
// Two-entry job queue between front and back.
`default_nettype none
module diu_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  diu_pkg::job_t      job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output diu_pkg::job_t      head_o
);
  import diu_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// File: src/diu_back.sv
// Back end: slices one group per cycle while the output is not stalled, looks it up and registers the beat.
`default_nettype none
module diu_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_valid_i,
  input  diu_pkg::job_t                    job_i,
  output logic                             pop_o,
  input  diu_pkg::dict_cfg_t               cfg_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [diu_pkg::SymBits-1:0]      symbol_o,
  output logic                             bad_index_o,
  output logic                             last_in_run_o
);
  import diu_pkg::*;

  logic [1:0]           grp_q;
  logic                 out_valid_q;
  logic [SymBits-1:0]   symbol_q;
  logic                 bad_q, last_q;
  logic                 adv, fire, is_last, bad;
  logic [4:0]           sh;
  logic [QueueBits-1:0] grp_bits;
  logic [IdxBits-1:0]   mask, idx;
  logic [SizeBits-1:0]  size;

  assign adv     = !out_valid_q || !out_stall_i;
  assign fire    = job_valid_i && adv;
  assign is_last = ({1'b0, grp_q} + 3'd1) == job_i.ngroups;
  assign pop_o   = fire && is_last;

  always_comb begin
    size     = eff_size(cfg_i.size);
    sh       = 5'(grp_q) * 5'(job_i.width);
    grp_bits = job_i.bits >> sh;
    mask     = IdxBits'((5'd1 << job_i.width) - 5'd1);
    idx      = grp_bits[IdxBits-1:0] & mask;
    bad      = {1'b0, idx} >= size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= job_valid_i;
      end
      if (fire) begin
        grp_q <= is_last ? 2'd0 : grp_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      symbol_q <= bad ? '0 : cfg_i.entries[{idx, 3'b000} +: SymBits];
      bad_q    <= bad;
      last_q   <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = symbol_q;
  assign bad_index_o   = bad_q;
  assign last_in_run_o = last_q;

endmodule
`default_nettype wire

// File: src/dictionary_index_unpacker.sv
// Top level of the dictionary index unpacker.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid_i/in_stall_o | code_char_i, stream_start_i
//   out     | out | out_valid_o/out_stall_i| symbol_o, bad_index_o, last_in_run_o
//   cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each character yields 1 to 4 symbols, one per cycle from the back end's
// single lookup while the output is not stalled.
// The front takes a character per cycle while the two-entry queue has room.
// Reset clears carry bits, queue and output valid; dictionary regs reset to 0.
// A stalled output holds its beat while the back end waits.
`default_nettype none
`include "assert_macros.svh"
module dictionary_index_unpacker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [diu_pkg::CharBits-1:0] code_char_i,
  input  wire logic                         stream_start_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [diu_pkg::SymBits-1:0]       symbol_o,
  output logic                              bad_index_o,
  output logic                              last_in_run_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [63:0]                  cfg_data_i
);
  import diu_pkg::*;

  logic [SizeBits-1:0] size_q;
  logic [63:0]         ent_lo_q, ent_hi_q;
  logic                cfg_wr, clear;
  dict_cfg_t           cfg;
  logic [2:0]          width;
  logic                push, full, pop, job_valid;
  job_t                job_in, job_head;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign clear       = cfg_wr && (cfg_index_i == RegDictSize);
  assign cfg.size    = size_q;
  assign cfg.entries = {ent_hi_q, ent_lo_q};
  assign width       = group_width(eff_size(size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= '0;
      ent_lo_q <= '0;
      ent_hi_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        RegDictSize:    size_q   <= cfg_data_i[SizeBits-1:0];
        RegEntriesLow:  ent_lo_q <= cfg_data_i;
        RegEntriesHigh: ent_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  diu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_char_i    (code_char_i),
    .stream_start_i (stream_start_i),
    .width_i        (width),
    .clear_i        (clear),
    .push_o         (push),
    .job_o          (job_in),
    .full_i         (full)
  );

  diu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .head_o  (job_head)
  );

  diu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .pop_o         (pop),
    .cfg_i         (cfg),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_o      (symbol_o),
    .bad_index_o   (bad_index_o),
    .last_in_run_o (last_in_run_o)
  );

  `DIU_ASSERT(a_bad_zero, clk_i, rst_ni, !(out_valid_o && bad_index_o) || (symbol_o == '0))
  `DIU_ASSERT_NEXT(a_push_queued, clk_i, rst_ni, in_valid_i && !in_stall_o, job_valid)
  `DIU_ASSERT(a_good_needs_dict, clk_i, rst_ni, !(out_valid_o && !bad_index_o) || (size_q != '0))

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the dictionary index unpacker against a symbol predictor.
module testbench;
  import diu_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct {
    logic [7:0] symbol;
    logic       bad;
    logic       last;
  } sym_beat_t;

  class symbol_ledger;
    logic [4:0]   dict_size;
    logic [127:0] dict_bytes;
    logic [2:0]   carry_bits;
    int           carry_cnt;
    sym_beat_t    pending_syms[$];
    int           errors;

    function new();
      dict_size  = '0;
      dict_bytes = '0;
      carry_bits = '0;
      carry_cnt  = 0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_syms.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        RegDictSize: begin
          dict_size  = data[4:0];
          carry_bits = '0;
          carry_cnt  = 0;
        end
        RegEntriesLow:  dict_bytes[63:0]   = data;
        RegEntriesHigh: dict_bytes[127:64] = data;
        default: ;
      endcase
    endfunction

    // unpack one character into its symbol beats
    function void take_char(logic [6:0] ch, logic start);
      int         size;
      int         width;
      int         qlen;
      int         n;
      int         idx;
      logic [9:0] q;
      sym_beat_t  beats[4];
      size  = (dict_size > 5'd16) ? 16 : int'(dict_size);
      width = (size <= 4) ? 2 : (size <= 8) ? 3 : 4;
      if (start) begin
        carry_bits = '0;
        carry_cnt  = 0;
      end
      qlen = carry_cnt;
      q    = 10'(carry_bits & 3'((1 << qlen) - 1)) | (10'(ch) << qlen);
      qlen += 7;
      n    = 0;
      while (qlen >= width && n < 4) begin
        idx             = int'(q) & ((1 << width) - 1);
        beats[n].bad    = (idx >= size);
        beats[n].symbol = beats[n].bad ? 8'h00 : dict_bytes[idx*8 +: 8];
        beats[n].last   = 1'b0;
        q    = q >> width;
        qlen -= width;
        n++;
      end
      if (n > 0) beats[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_syms.insert(pending_syms.size(), beats[i]);
      if (qlen > 3) qlen = 3;
      carry_cnt  = qlen;
      carry_bits = 3'(int'(q) & ((1 << qlen) - 1));
    endfunction

    function void match_symbol(logic [7:0] symbol, logic bad, logic last);
      sym_beat_t want;
      if (pending_syms.size() == 0) begin
        $display("%0t: unexpected beat: symbol %02h bad %0b last %0b",
                 $time, symbol, bad, last);
        errors++;
        return;
      end
      want = pending_syms.pop_front();
      if (symbol !== want.symbol) begin
        $display("%0t: symbol: expected %02h, got %02h", $time, want.symbol, symbol);
        errors++;
      end
      if (bad !== want.bad) begin
        $display("%0t: bad_index: expected %0b, got %0b", $time, want.bad, bad);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_in_run: expected %0b, got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [6:0]  code_char_i    = '0;
  logic        stream_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  symbol_o;
  logic        bad_index_o;
  logic        last_in_run_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = '0;
  logic [63:0] cfg_data_i     = '0;

  symbol_ledger ledger = new();
  bit           no_gaps = 1'b0;
  int           hold_off = 0;

  dictionary_index_unpacker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_char_i    (code_char_i),
    .stream_start_i (stream_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .bad_index_o    (bad_index_o),
    .last_in_run_o  (last_in_run_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_char(input logic [6:0] ch, input logic start);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    code_char_i    <= ch;
    stream_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.take_char(ch, start);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.write_reg(idx, data);
  endtask

  task automatic configure(input logic [4:0] size, input logic [63:0] lo,
                           input logic [63:0] hi);
    logic [63:0] size_word;
    size_word      = {$urandom, $urandom};
    size_word[4:0] = size;
    write_reg(RegEntriesLow, lo);
    write_reg(RegUnused, {$urandom, $urandom});
    write_reg(RegDictSize, size_word);
    write_reg(RegEntriesHigh, hi);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // receiver: random stall per beat, long hold-off on request
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      n = draw_gap();
      if (hold_off > 0) begin
        n        = hold_off;
        hold_off = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ledger.match_symbol(symbol_o, bad_index_o, last_in_run_o);
    end
  end

  initial begin
    logic [4:0]  size;
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty dictionary out of reset: everything flagged
    send_char(7'h00, 1'b1);
    send_char(7'h7F, 1'b0);
    send_char(7'h2A, 1'b0);
    settle();

    configure(5'd16, 64'h8877665544332211, 64'hFFEEDDCCBBAA9900);
    send_char(7'h7F, 1'b1);
    send_char(7'h00, 1'b0);
    send_char(7'h55, 1'b0);
    send_char(7'h2A, 1'b0);
    send_char(7'h7F, 1'b1);
    settle();

    // oversized size caps at 16
    configure(5'd31, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    send_char(7'h7F, 1'b0);
    send_char(7'h01, 1'b0);
    send_char(7'h4C, 1'b0);
    settle();

    configure(5'd4, '1, '0);
    send_char(7'h7F, 1'b0);
    send_char(7'h7F, 1'b0);
    send_char(7'h00, 1'b1);
    send_char(7'h7F, 1'b0);
    settle();

    configure(5'd5, 64'h1020304050607080, 64'h0);
    send_char(7'h7F, 1'b0);
    send_char(7'h6D, 1'b0);
    send_char(7'h12, 1'b0);
    settle();

    configure(5'd8, '1, '1);
    send_char(7'h7F, 1'b0);
    send_char(7'h00, 1'b0);
    send_char(7'h3C, 1'b0);
    settle();

    configure(5'd1, 64'h00000000000000A5, '1);
    send_char(7'h7F, 1'b0);
    send_char(7'h00, 1'b0);
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       size = 5'd16;
        1:       size = 5'd31;
        2:       size = 5'd0;
        3:       size = 5'd2;
        default: size = 5'($urandom_range(0, 31));
      endcase
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if (p == 3) begin
        lo = '1;
        hi = '1;
      end
      configure(size, lo, hi);
      no_gaps = (p == 5 || p == 8);
      if (p == 5) hold_off = 150;
      for (int i = 0; i < 31; i++) begin
        send_char(7'($urandom), $urandom_range(0, 7) == 0);
      end
      settle();
      no_gaps = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("dictionary_index_unpacker regression: pass");
    end else begin
      $display("dictionary_index_unpacker regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dictionary_index_unpacker regression: fail");
    $finish;
  end

endmodule
